FILE: hw/rtl/cubic_bezier_easing_newton_defines.svh
// ---------------------------------------------------------------------------
// cubic bezier easing assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_NEWTON_DEFINES_SVH
`define CUBIC_BEZIER_EASING_NEWTON_DEFINES_SVH

// same-cycle implication
`define CBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbe assertion failed");

// next-cycle implication
`define CBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbe assertion failed");

`endif

FILE: hw/rtl/cbe_pkg.sv
// ---------------------------------------------------------------------------
// cbe_pkg
// types and constants shared by the bezier easing evaluator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int DIV_QBITS = 24;
  localparam int REM_W     = 61;
  localparam int DEN_W     = 39;
  localparam int CMP_W     = DEN_W + DIV_QBITS;

  typedef struct packed {
    logic [15:0] x_in;
    logic [6:0]  ctrl_x1;
    logic [6:0]  ctrl_y1;
    logic [6:0]  ctrl_x2;
    logic [6:0]  ctrl_y2;
  } in_item_t;

  typedef struct packed {
    logic [15:0] y_out;
    logic        converged;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic                 ovf;
    logic [REM_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [DIV_QBITS-1:0] q;
  } div_lane_t;

endpackage

FILE: hw/rtl/cbe_div_cell.sv
// ---------------------------------------------------------------------------
// cbe_div_cell
// one restoring division step, resolves a single quotient bit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbe_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cbe_pkg::div_lane_t lane_i,
  output cbe_pkg::div_lane_t lane_o
);
  import cbe_pkg::*;

  logic [CMP_W-1:0] trial;
  logic             ge;
  div_lane_t        lane_nxt;
  div_lane_t        lane_r;

  assign trial = CMP_W'(lane_i.den) << BIT;
  assign ge    = CMP_W'(lane_i.rem) >= trial;

  always_comb begin
    lane_nxt = lane_i;
    if (ge) begin
      lane_nxt.rem    = lane_i.rem - trial[REM_W-1:0];
      lane_nxt.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.neg <= lane_nxt.neg;
    lane_r.ovf <= lane_nxt.ovf;
    lane_r.rem <= lane_nxt.rem;
    lane_r.den <= lane_nxt.den;
    lane_r.q   <= lane_nxt.q;
  end

  assign lane_o = lane_r;

endmodule

FILE: hw/rtl/cbe_divider.sv
// ---------------------------------------------------------------------------
// cbe_divider
// row of division cells, msb quotient bit first, one bit per cell
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbe_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  cbe_pkg::div_lane_t lane_i,
  output cbe_pkg::div_lane_t lane_o
);
  import cbe_pkg::*;

  div_lane_t lane [DIV_QBITS+1];

  assign lane[0] = lane_i;

  for (genvar i = 0; i < DIV_QBITS; i++) begin : g_cell
    cbe_div_cell #(.BIT(DIV_QBITS - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (lane[i]),
      .lane_o (lane[i+1])
    );
  end

  assign lane_o = lane[DIV_QBITS];

endmodule

FILE: hw/rtl/cubic_bezier_easing_newton.sv
// sequence: identity curves skip the solve; otherwise up to NEWTON_ITERS newton
// updates, each one a divide through the divider row, then y(t) is evaluated;
// a zero derivative ends the solve early
// throughput: one transaction at a time; each update is set by the 24-cell divider row
// reset: rst_n synchronous active low, clears control and sets tolerance to 16
// ---------------------------------------------------------------------------
// cubic_bezier_easing_newton
// cubic bezier easing curve evaluator, newton solve for t then y(t)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cubic_bezier_easing_newton_defines.svh"

module cubic_bezier_easing_newton #(
  parameter int NEWTON_ITERS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbe_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_tolerance
);
  import cbe_pkg::*;

  localparam int ITER_W = $clog2(NEWTON_ITERS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_CU   = 4'd2;
  localparam logic [3:0] S_F1   = 4'd3;
  localparam logic [3:0] S_F2   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_D1   = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_Y1   = 4'd9;
  localparam logic [3:0] S_Y2   = 4'd10;
  localparam logic [3:0] S_Y3   = 4'd11;
  localparam logic [3:0] S_Y4   = 4'd12;
  localparam logic [3:0] S_Y5   = 4'd13;
  localparam logic [3:0] S_Y6   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic signed [23:0] T_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] T_MIN   = 24'sh800000;
  localparam logic signed [8:0]  C127    = 9'sd127;
  localparam logic [22:0]        RECIP   = 23'd4227331;
  localparam logic [27:0]        Y_SAT   = 28'd133169152;
  localparam logic [15:0]        Y_ONE   = 16'd32768;

  logic [3:0]        state_r;
  logic [ITER_W-1:0] iter_r;
  logic [9:0]        tol_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic signed [9:0]  k0_r;
  logic signed [11:0] k0x3_r;
  logic signed [11:0] k1x2_r;
  logic signed [10:0] k1_r;
  logic signed [9:0]  k2_r;
  logic signed [9:0]  y1x3_r;
  logic signed [9:0]  y2x3_r;
  logic signed [28:0] x127_r;
  logic signed [23:0] t_r;
  logic signed [27:0] t2_r;
  logic signed [29:0] t3_r;
  logic signed [41:0] f_r;
  logic signed [39:0] d_r;
  logic               conv_r;
  logic signed [30:0] p_r;
  logic signed [27:0] rr_r;
  logic signed [30:0] q2_r;
  logic signed [43:0] ya_r;
  logic               ysat_r;
  logic [21:0]        w_r;
  logic [15:0]        y_r;

  // arithmetic terms
  logic signed [47:0] sq_w;
  logic signed [50:0] cu_w;
  logic signed [41:0] k2t_w;
  logic signed [41:0] k1t2_w;
  logic signed [41:0] k0t3_w;
  logic signed [41:0] e_w;
  logic [40:0]        abs_e_w;
  logic [21:0]        lim_w;
  logic               within_w;
  logic signed [39:0] k1t_w;
  logic signed [39:0] k0t2_w;
  logic [DEN_W-1:0]   abs_d_w;
  logic [REM_W-1:0]   num_w;
  logic signed [24:0] r_w;
  logic signed [51:0] t2r_w;
  logic signed [49:0] rsq_w;
  logic signed [54:0] trr_w;
  logic signed [43:0] y3t_w;
  logic signed [43:0] yb_w;
  logic signed [43:0] yc_w;
  logic signed [43:0] v_w;
  logic [44:0]        yq_w;
  logic signed [25:0] qs_w;
  logic signed [25:0] tn_w;
  logic signed [23:0] tsat_w;
  logic signed [11:0] x1_w;
  logic signed [11:0] y1_w;
  logic signed [11:0] x2_w;
  logic signed [11:0] y2_w;
  logic signed [11:0] k0_w;
  logic signed [11:0] k1_w;

  div_lane_t div_in;
  div_lane_t div_out;

  assign x1_w = {5'd0, in_data.ctrl_x1};
  assign y1_w = {5'd0, in_data.ctrl_y1};
  assign x2_w = {5'd0, in_data.ctrl_x2};
  assign y2_w = {5'd0, in_data.ctrl_y2};
  assign k0_w = 12'sd127 + 12'sd3 * x1_w - 12'sd3 * x2_w;
  assign k1_w = 12'sd3 * x2_w - 12'sd6 * x1_w;

  assign sq_w     = t_r * t_r;
  assign cu_w     = t2_r * t_r;
  assign k2t_w    = k2_r * t_r;
  assign k1t2_w   = k1_r * t2_r;
  assign k0t3_w   = k0_r * t3_r;
  assign e_w      = x127_r - f_r;
  assign abs_e_w  = e_w[41] ? 41'(-e_w) : e_w[40:0];
  assign lim_w    = 22'(tol_r) * 22'd4064;
  assign within_w = abs_e_w <= 41'(lim_w);
  assign k1t_w    = k1x2_r * t_r;
  assign k0t2_w   = k0x3_r * t2_r;
  assign abs_d_w  = d_r[39] ? DEN_W'(-d_r) : d_r[DEN_W-1:0];
  assign num_w    = {abs_e_w, 20'd0};

  assign r_w   = 25'sh100000 - 25'(t_r);
  assign t2r_w = t2_r * r_w;
  assign rsq_w = r_w * r_w;
  assign trr_w = t_r * rr_r;
  assign y3t_w = t3_r * C127;
  assign yb_w  = y2x3_r * p_r;
  assign yc_w  = y1x3_r * q2_r;
  assign v_w   = ya_r + 44'sd2032;
  assign yq_w  = 45'(w_r) * 45'(RECIP);

  assign qs_w = div_out.neg ? -$signed({2'b00, div_out.q}) : $signed({2'b00, div_out.q});
  assign tn_w = 26'(t_r) + qs_w;

  always_comb begin
    if (div_out.ovf) begin
      tsat_w = div_out.neg ? T_MIN : T_MAX;
    end else if (tn_w > 26'(T_MAX)) begin
      tsat_w = T_MAX;
    end else if (tn_w < 26'(T_MIN)) begin
      tsat_w = T_MIN;
    end else begin
      tsat_w = tn_w[23:0];
    end
  end

  always_comb begin
    div_in     = '0;
    div_in.vld = (state_r == S_DCHK) && (d_r != '0);
    div_in.neg = e_w[41] ^ d_r[39];
    div_in.ovf = CMP_W'(num_w) >= (CMP_W'(abs_d_w) << DIV_QBITS);
    div_in.rem = num_w;
    div_in.den = abs_d_w;
  end

  cbe_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .lane_i (div_in),
    .lane_o (div_out)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      tol_r       <= 10'd16;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol_r <= cfg_tolerance;
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            iter_r <= '0;
            if (in_data.ctrl_x1 == in_data.ctrl_y1 && in_data.ctrl_x2 == in_data.ctrl_y2) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ:  state_r <= S_CU;
        S_CU:  state_r <= S_F1;
        S_F1:  state_r <= S_F2;
        S_F2:  state_r <= S_CHK;
        S_CHK: begin
          if (within_w || iter_r == ITER_W'(NEWTON_ITERS)) begin
            state_r <= S_Y1;
          end else begin
            state_r <= S_D1;
          end
        end
        S_D1: state_r <= S_DCHK;
        S_DCHK: begin
          if (d_r == '0) begin
            state_r <= S_Y1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_out.vld) begin
            iter_r  <= iter_r + 1'b1;
            state_r <= S_SQ;
          end
        end
        S_Y1: state_r <= S_Y2;
        S_Y2: state_r <= S_Y3;
        S_Y3: state_r <= S_Y4;
        S_Y4: state_r <= S_Y5;
        S_Y5: state_r <= S_Y6;
        S_Y6: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        k0_r   <= k0_w[9:0];
        k0x3_r <= 12'sd3 * k0_w;
        k1_r   <= k1_w[10:0];
        k1x2_r <= k1_w <<< 1;
        k2_r   <= 10'(12'sd3 * x1_w);
        y1x3_r <= 10'(12'sd3 * y1_w);
        y2x3_r <= 10'(12'sd3 * y2_w);
        x127_r <= $signed({1'b0, 28'(in_data.x_in) * 28'd4064});
        t_r    <= $signed({3'b000, in_data.x_in, 5'd0});
        conv_r <= 1'b1;
        y_r    <= (in_data.x_in > Y_ONE) ? Y_ONE : in_data.x_in;
      end
      S_SQ: t2_r <= sq_w[47:20];
      S_CU: begin
        t3_r <= cu_w[49:20];
        f_r  <= k2t_w;
      end
      S_F1: f_r <= f_r + k1t2_w;
      S_F2: f_r <= f_r + k0t3_w;
      S_CHK: begin
        conv_r <= within_w;
        d_r    <= $signed({1'b0, k2_r[8:0], 20'd0}) + k1t_w;
      end
      S_D1: d_r <= d_r + k0t2_w;
      S_DIV: begin
        if (div_out.vld) begin
          t_r <= tsat_w;
        end
      end
      S_Y1: begin
        p_r  <= t2r_w[50:20];
        ya_r <= y3t_w;
      end
      S_Y2: rr_r <= rsq_w[47:20];
      S_Y3: begin
        ya_r <= ya_r + yb_w;
        q2_r <= trr_w[50:20];
      end
      S_Y4: ya_r <= ya_r + yc_w;
      S_Y5: begin
        ysat_r <= !ya_r[43] && (v_w >= $signed({16'd0, Y_SAT}));
        w_r    <= ya_r[43] ? '0 : v_w[26:5];
      end
      S_Y6: y_r <= ysat_r ? Y_ONE : yq_w[44:29];
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.y_out     <= y_r;
          out_data_r.converged <= conv_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `CBE_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE)
  `CBE_ASSERT_IMP(a_div_in_wait, div_out.vld, state_r == S_DIV)
  `CBE_ASSERT_IMP(a_y_range, out_valid, out_data.y_out <= Y_ONE)
  `CBE_ASSERT_IMP(a_iter_bound, state_r != S_IDLE, iter_r <= ITER_W'(NEWTON_ITERS))

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench for cubic_bezier_easing_newton
// drives progress values and control points in bursts against a stalling
// receiver, predicts each eased value with a fixed point newton solver and
// checks every result transaction in order across several tolerance settings
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cbe_pkg::*;

  localparam int ITERS     = 15;
  localparam int FRAC      = 20;
  localparam int SETTLE    = 600;
  localparam int N_PHASES  = 5;
  localparam int PER_PHASE = 360;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [9:0] cfg_tolerance;

  in_item_t  pending_items[$];
  out_item_t eased_expected[$];
  logic [9:0] tol_now;
  int err_count;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_phase_left;

  cubic_bezier_easing_newton #(.NEWTON_ITERS(ITERS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_tolerance(cfg_tolerance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fl_shift(longint v);
    return v >>> FRAC;
  endfunction

  function automatic bit near_target(longint f127, longint x127, logic [9:0] tol);
    longint e;
    e = f127 - x127;
    if (e < 0) e = -e;
    return e <= longint'(tol) * 32 * 127;
  endfunction

  function automatic longint curve_x127(longint t, longint k0, longint k1, longint k2);
    longint t2;
    longint t3;
    t2 = fl_shift(t * t);
    t3 = fl_shift(t2 * t);
    return k0 * t3 + k1 * t2 + k2 * t;
  endfunction

  function automatic out_item_t ease_value(in_item_t it, logic [9:0] tol);
    out_item_t res;
    longint x, x1, y1, x2, y2, k0, k1, k2, xq, x127, t, t2, t3, r, y127, y, f, d;
    res = '0;
    x  = longint'(it.x_in);
    x1 = longint'(it.ctrl_x1);
    y1 = longint'(it.ctrl_y1);
    x2 = longint'(it.ctrl_x2);
    y2 = longint'(it.ctrl_y2);
    if (x1 == y1 && x2 == y2) begin
      res.y_out = (x > 32768) ? 16'd32768 : it.x_in;
      res.converged = 1'b1;
      return res;
    end
    k0 = 127 + 3 * x1 - 3 * x2;
    k1 = 3 * x2 - 6 * x1;
    k2 = 3 * x1;
    xq = x * 32;
    x127 = xq * 127;
    t = xq;
    for (int n = 0; n < ITERS; n++) begin
      f = curve_x127(t, k0, k1, k2);
      if (near_target(f, x127, tol)) break;
      t2 = fl_shift(t * t);
      d = 3 * k0 * t2 + 2 * k1 * t + (k2 <<< FRAC);
      if (d == 0) break;
      t = t + ((x127 - f) * (longint'(1) <<< FRAC)) / d;
      if (t > (longint'(8) <<< FRAC) - 1) t = (longint'(8) <<< FRAC) - 1;
      if (t < -(longint'(8) <<< FRAC)) t = -(longint'(8) <<< FRAC);
    end
    res.converged = near_target(curve_x127(t, k0, k1, k2), x127, tol);
    t2 = fl_shift(t * t);
    t3 = fl_shift(t2 * t);
    r = (longint'(1) <<< FRAC) - t;
    y127 = 127 * t3 + 3 * y2 * fl_shift(t2 * r) + 3 * y1 * fl_shift(t * fl_shift(r * r));
    if (y127 < 0) y = 0;
    else begin
      y = (y127 + 2032) / 4064;
      if (y > 32768) y = 32768;
    end
    res.y_out = y[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall)
        eased_expected.insert(eased_expected.size(), ease_value(in_data, tol_now));
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else
          burst_left <= burst_left - 1;
      end else
        in_valid <= 1'b0;
    end
  end

  // monitor: checks results, stalls on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall        <= 1'b0;
      stall_mode       <= 0;
      stall_phase_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (eased_expected.size() == 0)
          report_mismatch("unexpected transaction", out_data.y_out, -1);
        else begin
          out_item_t want;
          want = eased_expected.pop_front();
          if (out_data.y_out !== want.y_out)
            report_mismatch("y_out", out_data.y_out, want.y_out);
          if (out_data.converged !== want.converged)
            report_mismatch("converged", out_data.converged, want.converged);
        end
      end
      if (stall_phase_left == 0) begin
        stall_mode       <= $urandom_range(0, 3);
        stall_phase_left <= $urandom_range(50, 400);
      end else
        stall_phase_left <= stall_phase_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (stall_phase_left % 7 < 4);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  function automatic in_item_t make_item(int x, int x1, int y1, int x2, int y2);
    in_item_t it;
    it.x_in = x[15:0];
    it.ctrl_x1 = x1[6:0];
    it.ctrl_y1 = y1[6:0];
    it.ctrl_x2 = x2[6:0];
    it.ctrl_y2 = y2[6:0];
    return it;
  endfunction

  task automatic queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic write_tolerance(logic [9:0] val);
    cfg_valid     <= 1'b1;
    cfg_tolerance <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_now = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || eased_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [9:0] tol_set[N_PHASES];
    in_item_t it;
    int x;
    tol_set = '{10'd16, 10'd0, 10'd1023, 10'd5, 10'd100};
    err_count     = 0;
    tol_now       = 10'd16;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_tolerance = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 3) tol_set[p] = $urandom_range(1, 1022);
      write_tolerance(tol_set[p]);
      if (p == 0 || p == 1) begin
        queue_item(make_item(0, 10, 80, 60, 20));
        queue_item(make_item(32768, 10, 80, 60, 20));
        queue_item(make_item(65535, 10, 80, 60, 20));
        queue_item(make_item(1, 127, 0, 0, 127));
        queue_item(make_item(16384, 40, 40, 90, 90));
        queue_item(make_item(65535, 0, 0, 127, 127));
        queue_item(make_item(40000, 127, 127, 0, 0));
        queue_item(make_item(32768, 0, 5, 127, 3));
        queue_item(make_item(16384, 0, 0, 127, 0));
        queue_item(make_item(30000, 127, 127, 127, 0));
        queue_item(make_item(2000, 127, 0, 127, 0));
        queue_item(make_item(8000, 64, 127, 0, 127));
        queue_item(make_item(21845, 127, 127, 127, 127));
        queue_item(make_item(50000, 30, 0, 100, 127));
        queue_item(make_item(1000, 0, 127, 127, 0));
        queue_item(make_item(31000, 100, 0, 127, 0));
        queue_item(make_item(43690, 85, 42, 21, 106));
      end
      for (int i = 0; i < PER_PHASE; i++) begin
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
        it = make_item(x, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127));
        if ($urandom_range(0, 9) == 0) begin
          it.ctrl_y1 = it.ctrl_x1;
          it.ctrl_y2 = it.ctrl_x2;
        end
        queue_item(it);
      end
      wait_idle();
    end
    if (err_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_div_cell.sv
hw/rtl/cbe_divider.sv
hw/rtl/cubic_bezier_easing_newton.sv
dv/testbench.sv
